[src/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg
// Shared constants, request codes and types of the line edit buffer engine.
// ----------------------------------------------------------------------------
package leb_pkg;

	localparam int CAPACITY = 256;
	localparam int AW       = $clog2(CAPACITY);
	localparam int LW       = AW + 1;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] NL_RESET  = 8'd10;

	localparam logic [3:0] REQ_INSERT    = 4'd0;
	localparam logic [3:0] REQ_RIGHT     = 4'd1;
	localparam logic [3:0] REQ_LEFT      = 4'd2;
	localparam logic [3:0] REQ_HOME      = 4'd3;
	localparam logic [3:0] REQ_END       = 4'd4;
	localparam logic [3:0] REQ_BACKSPACE = 4'd5;
	localparam logic [3:0] REQ_DELETE    = 4'd6;
	localparam logic [3:0] REQ_WORD_R    = 4'd7;
	localparam logic [3:0] REQ_WORD_L    = 4'd8;
	localparam logic [3:0] REQ_DEL_WORD  = 4'd9;
	localparam logic [3:0] REQ_DEL_START = 4'd10;
	localparam logic [3:0] REQ_CLEAR     = 4'd11;
	localparam logic [3:0] REQ_ESC_QUERY = 4'd12;
	localparam logic [3:0] REQ_READ      = 4'd13;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BADNL = 2'd2;

	typedef struct packed {
		logic [3:0] req_type;
		logic [7:0] char_code;
		logic [7:0] read_index;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] removed_count;
		logic       escaped;
		logic [7:0] read_char;
		logic [8:0] cursor;
		logic [8:0] length;
		logic [8:0] line_start;
	} rsp_t;

	function automatic logic is_word(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

[src/leb_if.sv]
// ----------------------------------------------------------------------------
// leb_if
// Request, response and configuration channels of the line edit buffer engine.
// ----------------------------------------------------------------------------
interface leb_req_if;
	logic       valid;
	logic       ready;
	logic [3:0] req_type;
	logic [7:0] char_code;
	logic [7:0] read_index;
	modport source (output valid, req_type, char_code, read_index, input ready);
	modport sink (input valid, req_type, char_code, read_index, output ready);
endinterface

interface leb_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [8:0] removed_count;
	logic       escaped;
	logic [7:0] read_char;
	logic [8:0] cursor;
	logic [8:0] length;
	logic [8:0] line_start;
	modport source (output valid, status, removed_count, escaped, read_char, cursor,
		length, line_start, input ready);
	modport sink (input valid, status, removed_count, escaped, read_char, cursor,
		length, line_start, output ready);
endinterface

interface leb_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

[src/leb_mem.sv]
// ----------------------------------------------------------------------------
// leb_mem
// Character store: one write and one registered read port.
// ----------------------------------------------------------------------------
module leb_mem (
	input  logic                  clk,
	input  logic                  we,
	input  logic [leb_pkg::AW-1:0] waddr,
	input  logic [7:0]            wdata,
	input  logic [leb_pkg::AW-1:0] raddr,
	output logic [7:0]            rdata
);

	logic [7:0] mem [leb_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/leb_seq.sv]
// ----------------------------------------------------------------------------
// leb_seq
// Edit sequencer: walks the store one character per step for shifts and scans.
// ----------------------------------------------------------------------------
module leb_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  leb_pkg::req_t req,
	input  logic [7:0]    nl_code,
	input  logic          take,
	output logic          idle,
	output logic          done,
	output leb_pkg::rsp_t res
);

	localparam int AW = leb_pkg::AW;
	localparam int LW = leb_pkg::LW;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NL   = 4'd1;
	localparam logic [3:0] S_SHR  = 4'd2;
	localparam logic [3:0] S_INS  = 4'd3;
	localparam logic [3:0] S_SHL  = 4'd4;
	localparam logic [3:0] S_WRA  = 4'd5;
	localparam logic [3:0] S_WRB  = 4'd6;
	localparam logic [3:0] S_WLA  = 4'd7;
	localparam logic [3:0] S_WLB  = 4'd8;
	localparam logic [3:0] S_ESA  = 4'd9;
	localparam logic [3:0] S_ESB  = 4'd10;
	localparam logic [3:0] S_RD   = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	logic [3:0]    state_q;
	logic [LW-1:0] len_q, cur_q, seg_q, p_q, w_q, wa_q, removed_q;
	logic          pend_q, ph_q, esc_q;
	logic [7:0]    ch_q, ridx_q, rchar_q;
	logic [3:0]    op_q;
	logic [1:0]    status_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;
	logic          rd_word;
	logic          p_in_text;

	leb_mem u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_word   = leb_pkg::is_word(rdata);
	assign p_in_text = p_q < len_q;

	always_comb begin
		we    = 1'b0;
		waddr = wa_q[AW-1:0];
		wdata = rdata;
		raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.req_type == leb_pkg::REQ_READ) begin
					raddr = AW'(req.read_index);
				end else begin
					raddr = AW'(len_q - LW'(1));
				end
			end
			S_SHR: begin
				we    = pend_q;
				raddr = AW'(p_q - LW'(1));
			end
			S_INS: begin
				we    = 1'b1;
				waddr = cur_q[AW-1:0];
				wdata = ch_q;
			end
			S_SHL: begin
				we    = pend_q;
				raddr = p_q[AW-1:0];
			end
			S_WRA: raddr = AW'(p_q + LW'(1));
			S_WLA: raddr = AW'(p_q - LW'(1));
			S_ESA: raddr = AW'(p_q - LW'(1));
			default: raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			len_q   <= '0;
			cur_q   <= '0;
			seg_q   <= '0;
			pend_q  <= 1'b0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q  <= leb_pkg::ST_OK;
						removed_q <= '0;
						esc_q     <= 1'b0;
						rchar_q   <= '0;
						ch_q      <= req.char_code;
						ridx_q    <= req.read_index;
						op_q      <= req.req_type;
						pend_q    <= 1'b0;
						ph_q      <= 1'b0;
						p_q       <= cur_q;
						state_q   <= S_DONE;
						case (req.req_type)
							leb_pkg::REQ_INSERT: begin
								if (req.char_code == nl_code) begin
									if (len_q == '0) begin
										status_q <= leb_pkg::ST_BADNL;
									end else begin
										state_q <= S_NL;
									end
								end else if (len_q >= LW'(leb_pkg::CAPACITY)) begin
									status_q <= leb_pkg::ST_FULL;
								end else begin
									p_q     <= len_q;
									state_q <= S_SHR;
								end
							end
							leb_pkg::REQ_RIGHT: begin
								if (cur_q < len_q) cur_q <= cur_q + LW'(1);
							end
							leb_pkg::REQ_LEFT: begin
								if (cur_q > seg_q) cur_q <= cur_q - LW'(1);
							end
							leb_pkg::REQ_HOME: cur_q <= seg_q;
							leb_pkg::REQ_END:  cur_q <= len_q;
							leb_pkg::REQ_BACKSPACE: begin
								if (cur_q > seg_q) begin
									cur_q   <= cur_q - LW'(1);
									w_q     <= cur_q - LW'(1);
									state_q <= S_SHL;
								end
							end
							leb_pkg::REQ_DELETE: begin
								if (cur_q < len_q) begin
									p_q     <= cur_q + LW'(1);
									w_q     <= cur_q;
									state_q <= S_SHL;
								end
							end
							leb_pkg::REQ_WORD_R: state_q <= S_WRA;
							leb_pkg::REQ_WORD_L: state_q <= S_WLA;
							leb_pkg::REQ_DEL_WORD: begin
								if (cur_q > seg_q) begin
									w_q     <= cur_q;
									state_q <= S_WLA;
								end
							end
							leb_pkg::REQ_DEL_START: begin
								if (cur_q > seg_q) begin
									removed_q <= cur_q - seg_q;
									w_q       <= seg_q;
									cur_q     <= seg_q;
									state_q   <= S_SHL;
								end
							end
							leb_pkg::REQ_CLEAR: begin
								len_q <= '0;
								cur_q <= '0;
								seg_q <= '0;
							end
							leb_pkg::REQ_ESC_QUERY: begin
								p_q     <= len_q;
								state_q <= S_ESA;
							end
							leb_pkg::REQ_READ: state_q <= S_RD;
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_NL: begin
					// backslash-newline: drop the backslash, new segment at the end
					if (rdata != leb_pkg::BACKSLASH) begin
						status_q <= leb_pkg::ST_BADNL;
					end else begin
						len_q <= len_q - LW'(1);
						cur_q <= len_q - LW'(1);
						seg_q <= len_q - LW'(1);
					end
					state_q <= S_DONE;
				end
				S_SHR: begin
					if (p_q > cur_q) begin
						wa_q   <= p_q;
						pend_q <= 1'b1;
						p_q    <= p_q - LW'(1);
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_INS;
					end
				end
				S_INS: begin
					cur_q   <= cur_q + LW'(1);
					len_q   <= len_q + LW'(1);
					state_q <= S_DONE;
				end
				S_SHL: begin
					// p_q reads the source, w_q trails as destination
					if (p_in_text) begin
						wa_q   <= w_q;
						w_q    <= w_q + LW'(1);
						p_q    <= p_q + LW'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q  <= 1'b0;
						len_q   <= w_q;
						state_q <= S_DONE;
					end
				end
				S_WRA: begin
					if (p_in_text) begin
						p_q     <= p_q + LW'(1);
						state_q <= S_WRB;
					end else begin
						cur_q   <= p_q;
						state_q <= S_DONE;
					end
				end
				S_WRB: begin
					if (!ph_q) begin
						if (p_in_text && rd_word) ph_q <= 1'b1;
						state_q <= S_WRA;
					end else if (!(p_in_text && rd_word)) begin
						cur_q   <= p_q;
						state_q <= S_DONE;
					end else begin
						state_q <= S_WRA;
					end
				end
				S_WLA: begin
					if (p_q > seg_q) begin
						state_q <= S_WLB;
					end else begin
						cur_q <= p_q;
						if (op_q == leb_pkg::REQ_DEL_WORD) begin
							removed_q <= w_q - p_q;
							p_q       <= w_q;
							w_q       <= p_q;
							state_q   <= S_SHL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_WLB: begin
					if (!ph_q) begin
						if (rd_word) ph_q <= 1'b1;
						else p_q <= p_q - LW'(1);
						state_q <= S_WLA;
					end else if (rd_word) begin
						p_q     <= p_q - LW'(1);
						state_q <= S_WLA;
					end else begin
						// stop: reuse the exit path of S_WLA
						seg_q   <= seg_q;
						ph_q    <= 1'b0;
						state_q <= S_WLA;
						cur_q   <= p_q;
						if (op_q == leb_pkg::REQ_DEL_WORD) begin
							removed_q <= w_q - p_q;
							p_q       <= w_q;
							w_q       <= p_q;
							state_q   <= S_SHL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ESA: begin
					state_q <= (p_q != '0) ? S_ESB : S_DONE;
				end
				S_ESB: begin
					if (rdata == leb_pkg::BACKSLASH) begin
						esc_q   <= ~esc_q;
						p_q     <= p_q - LW'(1);
						state_q <= S_ESA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_RD: begin
					rchar_q <= ({{LW{1'b0}}, ridx_q} < {8'd0, len_q}) ? rdata : 8'd0;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign idle = state_q == S_IDLE;
	assign done = state_q == S_DONE;

	assign res.status        = status_q;
	assign res.removed_count = 9'(removed_q);
	assign res.escaped       = esc_q;
	assign res.read_char     = rchar_q;
	assign res.cursor        = 9'(cur_q);
	assign res.length        = 9'(len_q);
	assign res.line_start    = 9'(seg_q);

endmodule

[src/line_edit_buffer_engine.sv]
// ----------------------------------------------------------------------------
// line_edit_buffer_engine
// Console line editor over a fixed character store, one edit request per item.
// ----------------------------------------------------------------------------
// Usage:
//   req  : edit request (req_type, char_code, read_index), valid/ready.
//   rsp  : one response per request with status, removed count, escaped flag,
//          read character and cursor, length and line start after the edit.
//   cfg  : write of the newline code, accepted every cycle; it applies to
//          requests taken after the write.
// Sequencing: a request is taken only when the sequencer is idle. Insert and
//   deletions shift one character per cycle on the store's single write port;
//   word moves and the escaped query scan the text one character at a time.
// The response sits in an output register, so the next request is taken
// while a response waits; a stalled receiver holds the sequencer in its final
// state until the output register frees up.
// Reset: empty text, cursor and line start at 0, newline code 10. No store
// clearing pass is needed; characters beyond the length are never read.
// ----------------------------------------------------------------------------
module line_edit_buffer_engine (
	input  logic       clk,
	input  logic       arst_n,
	leb_req_if.sink    req,
	leb_rsp_if.source  rsp,
	leb_cfg_if.sink    cfg
);

	logic          idle, done, take, out_v_q;
	logic [7:0]    nl_q;
	leb_pkg::req_t req_d;
	leb_pkg::rsp_t res, out_q;

	assign req_d.req_type   = req.req_type;
	assign req_d.char_code  = req.char_code;
	assign req_d.read_index = req.read_index;

	assign req.ready = idle;
	assign cfg.ready = 1'b1;
	assign take      = done && (!out_v_q || rsp.ready);

	leb_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid && idle),
		.req    (req_d),
		.nl_code(nl_q),
		.take   (take),
		.idle   (idle),
		.done   (done),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nl_q    <= leb_pkg::NL_RESET;
			out_v_q <= 1'b0;
		end else begin
			if (cfg.valid) nl_q <= cfg.data;
			if (take) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	assign rsp.valid         = out_v_q;
	assign rsp.status        = out_q.status;
	assign rsp.removed_count = out_q.removed_count;
	assign rsp.escaped       = out_q.escaped;
	assign rsp.read_char     = out_q.read_char;
	assign rsp.cursor        = out_q.cursor;
	assign rsp.length        = out_q.length;
	assign rsp.line_start    = out_q.line_start;

endmodule

[src/leb_chk.sv]
// ----------------------------------------------------------------------------
// leb_chk
// Port-level checks of the line edit buffer engine, bound to the top level.
// ----------------------------------------------------------------------------
module leb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] status,
	input logic [8:0] cursor,
	input logic [8:0] length,
	input logic [8:0] line_start
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> line_start <= cursor && cursor <= length)
		else $error("line start, cursor, length out of order");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> length <= 9'(leb_pkg::CAPACITY))
		else $error("length beyond capacity");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == leb_pkg::ST_FULL |-> length == 9'(leb_pkg::CAPACITY))
		else $error("store full reported on a store with room");

endmodule

bind line_edit_buffer_engine leb_chk u_leb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.cursor    (rsp.cursor),
	.length    (rsp.length),
	.line_start(rsp.line_start)
);
